FILE: hdl/cubic_bezier_sampler_assert.svh
`ifndef CUBIC_BEZIER_SAMPLER_ASSERT_SVH
`define CUBIC_BEZIER_SAMPLER_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, off while in reset.
`define BCS_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, off while in reset.
`define BCS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bcs_pkg.sv
package bcs_pkg;

  localparam int COORD_W = 24;
  localparam int T_W     = 16;
  localparam int STEP_W  = 17;

  // power-basis coefficient widths
  localparam int C1_W = 27;
  localparam int C2_W = 28;
  localparam int C3_W = 27;

  localparam logic [STEP_W-1:0] STEP_RESET = 17'd4096;
  localparam int DEFAULT_MAX_SAMPLES = 64;

  // register stages inside one coordinate lane
  localparam int LANE_DEPTH = 7;

  localparam int IN_W  = 8 * COORD_W;
  localparam int OUT_W = 2 * COORD_W;

  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_SAMPLE_STEP = 2'd0;

  typedef struct packed {
    logic signed [C3_W-1:0]    c3;
    logic signed [C2_W-1:0]    c2;
    logic signed [C1_W-1:0]    c1;
    logic signed [COORD_W-1:0] p0;
  } coef_t;

  typedef struct packed {
    logic           valid;
    logic [T_W-1:0] t;
    logic           last;
  } issue_t;

endpackage

FILE: hdl/cubic_bezier_sampler.sv
// Channel   Dir  Payload                                         Handshake
// s_*       in   one segment: P0..P3, x and y, Q16.8             tvalid/tready
// m_*       out  one curve point per sample, last one tagged     tvalid/tready/tlast
// APB       in   sample_step at byte address 0                   psel/penable, pready=1
//
// Samples: a segment keeps the input closed while its N samples issue, N = min(ceil(65536/step),
// MAX_SAMPLES); the t sequencer issues one sample per cycle while the pipe advances. The first
// point issues t = 0 off the accepting edge, then passes the seven lane stages.
// Reset: synchronous; clears all valid bits, sample_step returns to 4096.
// Stalls: one enable drives the whole pipe, so m_tready low while m_tvalid is high freezes every stage.
module cubic_bezier_sampler
  import bcs_pkg::*;
#(
  parameter int MAX_SAMPLES = DEFAULT_MAX_SAMPLES
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y (24 bits each, lowest first)
  input  logic [IN_W-1:0]    s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  // sample_x, sample_y (24 bits each, lowest first)
  output logic [OUT_W-1:0]   m_tdata,
  output logic               m_tlast,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [STEP_W-1:0]         step;
  logic                      en;
  issue_t                    issue;
  coef_t                     coef_x;
  coef_t                     coef_y;
  logic signed [COORD_W-1:0] res_x;
  logic signed [COORD_W-1:0] res_y;

  // Valid and last travel beside the lane stages; bit LANE_DEPTH-1 sits
  // alongside the lane output registers.
  logic [LANE_DEPTH-1:0]     vld;
  logic [LANE_DEPTH-1:0]     lst;

  // Pipe advances whenever the output register is empty or being drained.
  assign en = ~m_tvalid | m_tready;

  bcs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .step    (step)
  );

  // Holds the segment as power-basis coefficients and walks t in Q0.16.
  bcs_seq #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (s_tdata),
    .step     (step),
    .adv      (en),
    .issue    (issue),
    .coef_x   (coef_x),
    .coef_y   (coef_y)
  );

  // Exact Horner evaluation, one lane per coordinate.
  bcs_lane u_lane_x (
    .clk    (clk),
    .en     (en),
    .t_in   (issue.t),
    .coef   (coef_x),
    .result (res_x)
  );

  bcs_lane u_lane_y (
    .clk    (clk),
    .en     (en),
    .t_in   (issue.t),
    .coef   (coef_y),
    .result (res_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LANE_DEPTH-2:0], issue.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lst <= {lst[LANE_DEPTH-2:0], issue.last};
    end
  end

  assign m_tvalid = vld[LANE_DEPTH-1];
  assign m_tlast  = lst[LANE_DEPTH-1];
  assign m_tdata  = {res_y, res_x};

endmodule

FILE: hdl/bcs_cfg.sv
module bcs_cfg
  import bcs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  output logic [STEP_W-1:0]   step
);

  logic hit;

  always_comb begin
    unique case (paddr)
      ADDR_SAMPLE_STEP: begin
        hit    = 1'b1;
        prdata = {{(PDATA_W-STEP_W){1'b0}}, step};
      end
      default: begin
        hit    = 1'b0;
        prdata = '0;
      end
    endcase
  end

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      step <= pwdata[STEP_W-1:0];
    end
  end

endmodule

FILE: hdl/bcs_seq.sv
module bcs_seq
  import bcs_pkg::*;
#(
  parameter int MAX_SAMPLES = DEFAULT_MAX_SAMPLES
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IN_W-1:0]   in_data,
  input  logic [STEP_W-1:0] step,
  input  logic              adv,
  output issue_t            issue,
  output coef_t             coef_x,
  output coef_t             coef_y
);

  localparam int CNT_W = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_SAMPLES - 1);

  // B(s) = P0 + c1 s + c2 s^2 + c3 s^3
  function automatic coef_t coef_calc(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b,
    input logic signed [COORD_W-1:0] c,
    input logic signed [COORD_W-1:0] d
  );
    logic signed [C2_W-1:0] ea, eb, ec, ed;
    coef_t r;
    ea   = C2_W'(a);
    eb   = C2_W'(b);
    ec   = C2_W'(c);
    ed   = C2_W'(d);
    r.c1 = C1_W'(3 * (eb - ea));
    r.c2 = C2_W'(3 * (ea - 2 * eb + ec));
    r.c3 = C3_W'((ed - ea) + 3 * (eb - ec));
    r.p0 = a;
    return r;
  endfunction

  logic                busy;
  logic [T_W-1:0]      t;
  logic [CNT_W-1:0]    cnt;
  logic [T_W+1:0]      t_sum;
  logic                last_now;

  assign t_sum    = {2'b00, t} + {1'b0, step};
  assign last_now = (t_sum[T_W+1:T_W] != 2'b00) || (cnt == CNT_LAST);
  assign in_ready = ~busy;

  assign issue.valid = busy;
  assign issue.t     = t;
  assign issue.last  = last_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_valid && in_ready) begin
      busy   <= 1'b1;
      t      <= '0;
      cnt    <= '0;
      coef_x <= coef_calc($signed(in_data[0*COORD_W +: COORD_W]),
                          $signed(in_data[2*COORD_W +: COORD_W]),
                          $signed(in_data[4*COORD_W +: COORD_W]),
                          $signed(in_data[6*COORD_W +: COORD_W]));
      coef_y <= coef_calc($signed(in_data[1*COORD_W +: COORD_W]),
                          $signed(in_data[3*COORD_W +: COORD_W]),
                          $signed(in_data[5*COORD_W +: COORD_W]),
                          $signed(in_data[7*COORD_W +: COORD_W]));
    end else if (busy && adv) begin
      if (last_now) begin
        busy <= 1'b0;
      end
      t   <= t_sum[T_W-1:0];
      cnt <= cnt + 1'b1;
    end
  end

endmodule

FILE: hdl/bcs_lane.sv
module bcs_lane
  import bcs_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic [T_W-1:0]            t_in,
  input  coef_t                     coef,
  output logic signed [COORD_W-1:0] result
);

  localparam int TS_W  = T_W + 1;
  localparam int P1_W  = C3_W + TS_W;
  localparam int H1_W  = P1_W + 1;
  localparam int SA_W  = 22;
  localparam int HA_W  = H1_W - SA_W;
  localparam int QAH_W = HA_W + TS_W;
  localparam int QAL_W = SA_W + 1 + TS_W;
  localparam int H2_W  = 62;
  localparam int SB_W  = 21;
  localparam int HB_W  = H2_W - 2 * SB_W;
  localparam int QBH_W = HB_W + TS_W;
  localparam int QBL_W = SB_W + 1 + TS_W;
  localparam int S_W   = H2_W + TS_W;
  localparam int N_W   = S_W + 1;
  localparam int FRAC  = 3 * T_W;
  localparam int R_W   = N_W - FRAC;

  localparam logic signed [N_W-1:0] RND   = N_W'(1) << (FRAC - 1);
  localparam logic signed [R_W-1:0] R_MAX = R_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [R_W-1:0] R_MIN = R_W'(-(1 << (COORD_W - 1)));

  // stage 1: c3 * t
  logic signed [P1_W-1:0]    s1_p;
  logic signed [C2_W-1:0]    s1_c2;
  logic signed [C1_W-1:0]    s1_c1;
  logic signed [COORD_W-1:0] s1_p0;
  logic [T_W-1:0]            s1_t;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p  <= $signed(coef.c3) * $signed({1'b0, t_in});
      s1_c2 <= coef.c2;
      s1_c1 <= coef.c1;
      s1_p0 <= coef.p0;
      s1_t  <= t_in;
    end
  end

  // stage 2: h1 = c3 t + c2 2^16
  logic signed [H1_W-1:0]    s2_h1;
  logic signed [C1_W-1:0]    s2_c1;
  logic signed [COORD_W-1:0] s2_p0;
  logic [T_W-1:0]            s2_t;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_h1 <= H1_W'(s1_p) + H1_W'($signed({s1_c2, {T_W{1'b0}}}));
      s2_c1 <= s1_c1;
      s2_p0 <= s1_p0;
      s2_t  <= s1_t;
    end
  end

  // stage 3: h1 * t as two partial products
  logic signed [QAH_W-1:0]   s3_qh;
  logic signed [QAL_W-1:0]   s3_ql;
  logic signed [C1_W-1:0]    s3_c1;
  logic signed [COORD_W-1:0] s3_p0;
  logic [T_W-1:0]            s3_t;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_qh <= $signed(s2_h1[H1_W-1:SA_W]) * $signed({1'b0, s2_t});
      s3_ql <= $signed({1'b0, s2_h1[SA_W-1:0]}) * $signed({1'b0, s2_t});
      s3_c1 <= s2_c1;
      s3_p0 <= s2_p0;
      s3_t  <= s2_t;
    end
  end

  // stage 4: h2 = h1 t + c1 2^32
  logic signed [H2_W-1:0]    s4_h2;
  logic signed [COORD_W-1:0] s4_p0;
  logic [T_W-1:0]            s4_t;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_h2 <= H2_W'($signed({s3_qh, {SA_W{1'b0}}})) + H2_W'(s3_ql)
             + H2_W'($signed({s3_c1, {(2*T_W){1'b0}}}));
      s4_p0 <= s3_p0;
      s4_t  <= s3_t;
    end
  end

  // stage 5: h2 * t as three partial products
  logic signed [QBH_W-1:0]   s5_qh;
  logic signed [QBL_W-1:0]   s5_qm;
  logic signed [QBL_W-1:0]   s5_ql;
  logic signed [COORD_W-1:0] s5_p0;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_qh <= $signed(s4_h2[H2_W-1:2*SB_W]) * $signed({1'b0, s4_t});
      s5_qm <= $signed({1'b0, s4_h2[2*SB_W-1:SB_W]}) * $signed({1'b0, s4_t});
      s5_ql <= $signed({1'b0, s4_h2[SB_W-1:0]}) * $signed({1'b0, s4_t});
      s5_p0 <= s4_p0;
    end
  end

  // stage 6: recombine h2 t
  logic signed [S_W-1:0]     s6_s;
  logic signed [COORD_W-1:0] s6_p0;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_s  <= S_W'($signed({s5_qh, {(2*SB_W){1'b0}}}))
             + S_W'($signed({s5_qm, {SB_W{1'b0}}})) + S_W'(s5_ql);
      s6_p0 <= s5_p0;
    end
  end

  // stage 7: add P0 2^48, round half up, saturate
  logic signed [N_W-1:0] n_sum;
  logic signed [R_W-1:0] r_q;

  assign n_sum = N_W'(s6_s) + N_W'($signed({s6_p0, {FRAC{1'b0}}})) + RND;
  assign r_q   = $signed(n_sum[N_W-1:FRAC]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (r_q > R_MAX) begin
        result <= $signed(R_MAX[COORD_W-1:0]);
      end else if (r_q < R_MIN) begin
        result <= $signed(R_MIN[COORD_W-1:0]);
      end else begin
        result <= $signed(r_q[COORD_W-1:0]);
      end
    end
  end

endmodule

FILE: hdl/bcs_checker.sv
`include "cubic_bezier_sampler_assert.svh"

module bcs_checker
  import bcs_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [OUT_W-1:0]   m_tdata,
  input logic               m_tlast,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [PDATA_W-1:0] pwdata,
  input logic [PDATA_W-1:0] prdata,
  input logic               pready
);

  // stalled point must hold
  `BCS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tlast),
    "output changed while stalled")

  // one segment at a time: taking a request closes the input
  `BCS_ASSERT_NEXT(a_seg_busy, clk, rst, s_tvalid && s_tready, !s_tready,
    "input still open after a segment was taken")

  // step register reads back what was written
  `BCS_ASSERT_NEXT(a_step_rb, clk, rst,
    psel && penable && pwrite && pready && (paddr == ADDR_SAMPLE_STEP),
    (paddr != ADDR_SAMPLE_STEP) || (prdata[STEP_W-1:0] == $past(pwdata[STEP_W-1:0])),
    "sample_step readback mismatch")

endmodule

bind cubic_bezier_sampler bcs_checker u_bcs_checker (.*);
